>>> src/grdd_pkg.sv
// shared constants, angle table and codes for the grid ray wall distance core
// used by grdd_divider and grid_ray_wall_distance_core
package grdd_pkg;

	localparam int MAP_CELLS_DEF   = 16;
	localparam int SCREEN_COLS_DEF = 88;
	localparam int FOV_UNITS       = 10923;
	localparam int HALF_FOV        = 5461;
	localparam int AXIS_PAD        = 13;
	localparam int CORDIC_STEPS    = 14;
	localparam logic signed [17:0] CORDIC_GAIN = 18'sd9949;
	localparam int DIV_W           = 28;

	localparam logic [2:0] REG_ROWS0 = 3'd0;
	localparam logic [2:0] REG_ROWS1 = 3'd1;
	localparam logic [2:0] REG_ROWS2 = 3'd2;
	localparam logic [2:0] REG_ROWS3 = 3'd3;
	localparam logic [2:0] REG_MAXD  = 3'd4;

	function automatic logic [13:0] atan_units(input logic [3:0] i);
		logic [13:0] r;
		unique case (i)
			4'd0: r = 14'd8192;
			4'd1: r = 14'd4836;
			4'd2: r = 14'd2555;
			4'd3: r = 14'd1297;
			4'd4: r = 14'd651;
			4'd5: r = 14'd326;
			4'd6: r = 14'd163;
			4'd7: r = 14'd81;
			4'd8: r = 14'd41;
			4'd9: r = 14'd20;
			4'd10: r = 14'd10;
			4'd11: r = 14'd5;
			4'd12: r = 14'd3;
			4'd13: r = 14'd1;
			default: r = 14'd0;
		endcase
		return r;
	endfunction

endpackage

>>> src/grdd_divider.sv
// restoring divider, one quotient bit per cycle
// depends on grdd_pkg for the operand width
module grdd_divider import grdd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] dividend,
	input  logic [15:0]      divisor,
	output logic             done,
	output logic [DIV_W-1:0] quotient
);

	logic [DIV_W-1:0] quo_q;
	logic [15:0]      rem_q;
	logic [15:0]      dsr_q;
	logic [4:0]       cnt_q;
	logic             busy_q;
	logic [17:0]      trial;
	logic [16:0]      rem_sh;

	assign rem_sh = {rem_q, quo_q[DIV_W-1]};
	assign trial  = {1'b0, rem_sh} - {2'b00, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'(DIV_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
				cnt_q <= cnt_q - 5'd1;
			end
		end
	end

	// the remainder stays below the divisor, so 16 bits hold it
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			if (!trial[17]) begin
				rem_q <= trial[15:0];
				quo_q <= {quo_q[DIV_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[15:0];
				quo_q <= {quo_q[DIV_W-2:0], 1'b0};
			end
		end
	end

	assign quotient = quo_q;

endmodule

>>> src/grid_ray_wall_distance_core.sv
// Grid ray wall distance core: casts the ray of one screen column over a wall map
// held in configuration registers and returns the fisheye-corrected wall distance
// on m_axis_tdata with the hit flag on m_axis_tuser. A beat is taken only while the
// core is idle. Its result follows a 14-step CORDIC run on a shared shift-add unit,
// four divisions on one restoring divider, a vertical and a horizontal march that
// each test one crossing per cycle (1 to MAP_CELLS crossings each) and, on a hit, a
// second CORDIC pass for the cosine and a multiply. The core takes no new beat until
// the result beat has been taken.
// depends on grdd_pkg and grdd_divider
module grid_ray_wall_distance_core import grdd_pkg::*; #(
	parameter int MAP_CELLS   = MAP_CELLS_DEF,
	parameter int SCREEN_COLS = SCREEN_COLS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [55:0] s_axis_tdata,   // pos_x, pos_y, view_angle, column, zero fill
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // distance
	output logic        m_axis_tuser,   // hit
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	typedef enum logic [10:0] {
		ST_IDLE  = 11'b00000000001,
		ST_ANGLE = 11'b00000000010,
		ST_NUDGE = 11'b00000000100,
		ST_CORD  = 11'b00000001000,
		ST_DIV   = 11'b00000010000,
		ST_VINIT = 11'b00000100000,
		ST_MARCH = 11'b00001000000,
		ST_HINIT = 11'b00010000000,
		ST_FCORD = 11'b00100000000,
		ST_MUL   = 11'b01000000000,
		ST_OUT   = 11'b10000000000
	} state_t;

	// column offset by reciprocal multiplication, exact for columns below 128
	localparam int REL_SHIFT = 17;
	localparam logic [31:0] REL_MUL = 32'((64'(FOV_UNITS) * 64'(2 ** REL_SHIFT)
		+ 64'(SCREEN_COLS) - 64'd1) / 64'(SCREEN_COLS));

	state_t state_q;

	logic [63:0] rows_q [4];
	logic [3:0]  maxd_q;

	logic [15:0] px_q, py_q, view_q, rel_q, ray_q;
	logic [6:0]  col_q;
	logic        right_q, up_q;

	// cordic shared unit
	logic signed [17:0] cx_q, cy_q;
	logic signed [17:0] cz_q;
	logic [3:0]         ci_q;
	logic               cflip_q;
	logic               second_q;

	// divisions: tan, sec, cot, csc
	logic [15:0] cm_q, sm_q;
	logic [1:0]  di_q;
	logic        dstart_q;
	logic        ddone;
	logic [DIV_W-1:0] dividend, quo;
	logic [15:0] divisor;
	logic [DIV_W-1:0] tan_q, sec_q, cot_q, csc_q;

	// march
	logic signed [31:0] mx_q, my_q, msx_q, msy_q;
	logic [31:0]        mt_q, mst_q;
	logic               mfirst_q, horiz_q;
	logic               hv_q;
	logic [31:0]        dv_q;
	logic               hit_q;
	logic [31:0]        best_q;
	logic [15:0]        dist_q;

	grdd_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(dstart_q), .dividend(dividend),
		.divisor(divisor), .done(ddone), .quotient(quo)
	);

	always_comb begin
		unique case (di_q)
			2'd0: begin dividend = {sm_q, 12'd0};      divisor = cm_q; end
			2'd1: begin dividend = 28'd16384 << 12;    divisor = cm_q; end
			2'd2: begin dividend = {cm_q, 12'd0};      divisor = sm_q; end
			default: begin dividend = 28'd16384 << 12; divisor = sm_q; end
		endcase
	end

	// angle helpers
	logic [38:0] relmul;
	logic [15:0] rel_c, dpart;
	assign relmul = 39'(col_q) * 39'(REL_MUL);
	assign rel_c  = 16'(relmul >> REL_SHIFT) + 16'(65536 - HALF_FOV);
	assign dpart  = {2'b00, ray_q[13:0]};

	// cordic start for an angle
	logic signed [17:0] za;
	logic signed [17:0] zs;
	logic               fl;
	always_comb begin
		za = second_q ? $signed({{2{rel_q[15]}}, rel_q})
		              : $signed({{2{ray_q[15]}}, ray_q});
		fl = 1'b0;
		zs = za;
		if (za > 18'sd16384) begin zs = za - 18'sd32768; fl = 1'b1; end
		else if (za < -18'sd16384) begin zs = za + 18'sd32768; fl = 1'b1; end
	end

	logic signed [17:0] dxs, dys;
	assign dxs = cy_q >>> ci_q;
	assign dys = cx_q >>> ci_q;

	// march cell lookup
	logic signed [31:0] mxa, mya;
	logic               outside, wall, over;
	logic [3:0]         cellx, celly;
	logic [63:0]        rowreg;
	always_comb begin
		mxa = right_q ? mx_q : mx_q - 32'sd1;
		mya = up_q ? my_q - 32'sd1 : my_q;
		outside = mxa[31] || mya[31] || (mxa[31:12] >= 20'(MAP_CELLS))
		          || (mya[31:12] >= 20'(MAP_CELLS));
		cellx  = mxa[15:12];
		celly  = mya[15:12];
		rowreg = rows_q[celly[3:2]];
		wall   = rowreg[{celly[1:0], cellx}];
		over   = !mfirst_q && (mt_q > {16'd0, maxd_q, 12'd0});
	end

	// first-crossing offsets
	logic [12:0] dxo, dyo;
	logic [40:0] ptan, psec, pcot, pcsc;
	assign dxo  = right_q ? 13'd4096 - {1'b0, px_q[11:0]} : {1'b0, px_q[11:0]};
	assign dyo  = up_q ? {1'b0, py_q[11:0]} : 13'd4096 - {1'b0, py_q[11:0]};
	assign ptan = 41'(dxo) * 41'(tan_q);
	assign psec = 41'(dxo) * 41'(sec_q);
	assign pcot = 41'(dyo) * 41'(cot_q);
	assign pcsc = 41'(dyo) * 41'(csc_q);

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = (state_q == ST_OUT);
	assign m_axis_tdata  = dist_q;
	assign m_axis_tuser  = hit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q[0] <= '0; rows_q[1] <= '0; rows_q[2] <= '0; rows_q[3] <= '0;
			maxd_q    <= 4'd6;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_ROWS0: rows_q[0] <= cfg_data;
				REG_ROWS1: rows_q[1] <= cfg_data;
				REG_ROWS2: rows_q[2] <= cfg_data;
				REG_ROWS3: rows_q[3] <= cfg_data;
				REG_MAXD:  maxd_q    <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			dstart_q <= 1'b0;
		end else begin
			dstart_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (s_axis_tvalid) state_q <= ST_ANGLE;
				ST_ANGLE: state_q <= ST_NUDGE;
				ST_NUDGE: state_q <= ST_CORD;
				ST_CORD: if (ci_q == 4'(CORDIC_STEPS - 1)) begin
					state_q  <= ST_DIV;
					dstart_q <= 1'b1;
				end
				ST_DIV: if (ddone) begin
					if (di_q == 2'd3) begin
						state_q <= ST_VINIT;
					end else begin
						dstart_q <= 1'b1;
					end
				end
				ST_VINIT: state_q <= ST_MARCH;
				ST_MARCH: if (outside || over || wall) begin
					if (!horiz_q) state_q <= ST_HINIT;
					else state_q <= ST_FCORD;
				end
				ST_HINIT: state_q <= ST_MARCH;
				ST_FCORD: if (!hit_q || ci_q == 4'(CORDIC_STEPS - 1)) begin
					state_q <= hit_q ? ST_MUL : ST_OUT;
				end
				ST_MUL: state_q <= ST_OUT;
				ST_OUT: if (m_axis_tready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				px_q   <= s_axis_tdata[15:0];
				py_q   <= s_axis_tdata[31:16];
				view_q <= s_axis_tdata[47:32];
				col_q  <= s_axis_tdata[54:48];
			end
			ST_ANGLE: begin
				rel_q <= rel_c;
				ray_q <= view_q + rel_c;
			end
			ST_NUDGE: begin
				logic [15:0] r;
				r = ray_q;
				if (dpart < 16'(AXIS_PAD)) r = ray_q - 16'(AXIS_PAD);
				else if (16'd16384 - dpart < 16'(AXIS_PAD)) r = ray_q + 16'(AXIS_PAD);
				ray_q    <= r;
				right_q  <= (r < 16'd16384) || (r > 16'd49152);
				up_q     <= r > 16'd32768;
				second_q <= 1'b0;
				cx_q     <= CORDIC_GAIN;
				cy_q     <= '0;
				ci_q     <= '0;
			end
			ST_CORD, ST_FCORD: begin
				if (state_q == ST_FCORD && !second_q) begin
					// load second angle
					second_q <= 1'b1;
					cx_q <= CORDIC_GAIN;
					cy_q <= '0;
					ci_q <= '0;
					cz_q <= '0;
				end else begin
					logic signed [17:0] z, x, y;
					z = (ci_q == '0) ? zs : cz_q;
					x = cx_q; y = cy_q;
					if (ci_q == '0) cflip_q <= fl;
					if (z >= 0) begin
						x = x - dxs; y = y + dys; z = z - $signed({4'd0, atan_units(ci_q)});
					end else begin
						x = x + dxs; y = y - dys; z = z + $signed({4'd0, atan_units(ci_q)});
					end
					if (ci_q == 4'(CORDIC_STEPS - 1)) begin
						logic flp;
						flp = (ci_q == '0) ? fl : cflip_q;
						if (flp) begin x = -x; y = -y; end
						cm_q <= (x == 0) ? 16'd1 : (x[17] ? 16'(-x) : 16'(x));
						sm_q <= (y == 0) ? 16'd1 : (y[17] ? 16'(-y) : 16'(y));
						di_q <= '0;
					end
					cx_q <= x; cy_q <= y; cz_q <= z;
					ci_q <= ci_q + 4'd1;
				end
			end
			ST_DIV: if (ddone) begin
				unique case (di_q)
					2'd0: tan_q <= quo;
					2'd1: sec_q <= quo;
					2'd2: cot_q <= quo;
					default: csc_q <= quo;
				endcase
				di_q <= di_q + 2'd1;
			end
			ST_VINIT: begin
				horiz_q  <= 1'b0;
				mfirst_q <= 1'b1;
				mx_q  <= $signed({16'd0, px_q}) + (right_q ? $signed({19'd0, dxo})
				                                           : -$signed({19'd0, dxo}));
				my_q  <= $signed({16'd0, py_q}) + (up_q ? -$signed(32'(ptan >> 12))
				                                      : $signed(32'(ptan >> 12)));
				msx_q <= right_q ? 32'sd4096 : -32'sd4096;
				msy_q <= up_q ? -$signed(32'(tan_q)) : $signed(32'(tan_q));
				mt_q  <= 32'(psec >> 12);
				mst_q <= 32'(sec_q);
				hit_q <= 1'b0;
			end
			ST_HINIT: begin
				horiz_q  <= 1'b1;
				mfirst_q <= 1'b1;
				mx_q  <= $signed({16'd0, px_q}) + (right_q ? $signed(32'(pcot >> 12))
				                                           : -$signed(32'(pcot >> 12)));
				my_q  <= $signed({16'd0, py_q}) + (up_q ? -$signed({19'd0, dyo})
				                                      : $signed({19'd0, dyo}));
				msx_q <= right_q ? $signed(32'(cot_q)) : -$signed(32'(cot_q));
				msy_q <= up_q ? -32'sd4096 : 32'sd4096;
				mt_q  <= 32'(pcsc >> 12);
				mst_q <= 32'(csc_q);
			end
			ST_MARCH: begin
				if (outside || over) begin
				end else if (wall) begin
					if (!horiz_q) begin
						hv_q <= 1'b1; dv_q <= mt_q;
					end
				end else begin
					mx_q <= mx_q + msx_q;
					my_q <= my_q + msy_q;
					mt_q <= mt_q + mst_q;
					mfirst_q <= 1'b0;
				end
				if (!horiz_q && (outside || over)) hv_q <= 1'b0;
				if (horiz_q && (outside || over || wall)) begin
					logic hh;
					hh = !(outside || over);
					hit_q <= hv_q || hh;
					if (hv_q && hh) best_q <= (dv_q < mt_q) ? dv_q : mt_q;
					else best_q <= hv_q ? dv_q : mt_q;
					second_q <= 1'b0;
					dist_q <= 16'hFFFF;
				end
			end
			ST_MUL: begin
				logic [47:0] prod;
				prod = 48'(best_q) * 48'(cx_q[15:0]) + 48'd8192;
				if (cx_q <= 0) dist_q <= '0;
				else dist_q <= (prod[47:14] > 34'd65535) ? 16'hFFFF : prod[29:14];
			end
			default: ;
		endcase
	end

endmodule
